>>> hdl/assert_macros.svh
// Assertion helpers. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/ldf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ldf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 512;
  localparam int MAX_LAG     = 64;
  localparam int STORE_DEPTH = MAX_WINDOW + MAX_LAG;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int WLEN_W      = 10;
  localparam int WCNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int LAG_W       = 6;
  localparam int MODE_W      = 2;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int ACC_W       = 48;
  localparam int VALUE_W     = 48;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_W       = 48;
  localparam int DIV_W       = NUM_W + FRAC_BITS;
  localparam int DIVISOR_W   = 48;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int REG_IDX_W   = 2;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_ACF  = 2'd0,
    MODE_AMDF = 2'd1,
    MODE_ASDF = 2'd2,
    MODE_YIN  = 2'd3
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE          = 2'd0,
    REG_WINDOW_LENGTH = 2'd1,
    REG_LAG_START     = 2'd2,
    REG_LAG_END       = 2'd3
  } reg_idx_t;

  localparam mode_t             MODE_RESET      = MODE_ASDF;
  localparam logic [WLEN_W-1:0] WLEN_RESET      = 10'd256;
  localparam logic [LAG_W-1:0]  LAG_START_RESET = 6'd1;
  localparam logic [LAG_W-1:0]  LAG_END_RESET   = 6'd63;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
  } in_item_t;

  typedef struct packed {
    logic [LAG_W-1:0]          lag;
    logic signed [VALUE_W-1:0] value;
    logic                      last_result;
  } out_item_t;

  typedef struct packed {
    mode_t             mode;
    logic [WCNT_W-1:0] window;
    logic [LAG_W-1:0]  lag_start;
    logic [LAG_W-1:0]  lag_end;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [IDX_W-1:0] idx;
    logic [LAG_W-1:0] lag;
    logic             mac_clear;
    logic             sum_clear;
    logic             prep;
    logic             div_start;
    logic             emit;
    logic             last;
    logic             fill_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAG_INIT,
    ST_ISSUE,
    ST_DRAIN,
    ST_PREP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_FINISH
  } ctrl_state_t;

endpackage

`default_nettype wire

>>> hdl/ldf_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module ldf_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ldf_pkg::DIV_W-1:0]        dividend,
  input  logic [ldf_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             done,
  output logic [ldf_pkg::DIV_W-1:0]        quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [ldf_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [ldf_pkg::DIVISOR_W-1:0]     rem_r;
  logic [ldf_pkg::DIV_W-1:0]         quo_r;
  logic [ldf_pkg::DIVISOR_W-1:0]     dsr_r;
  logic [ldf_pkg::DIVISOR_W:0]       shifted;
  logic [ldf_pkg::DIVISOR_W+1:0]     trial;
  logic                              ge;

  always_comb begin
    shifted = {rem_r, quo_r[ldf_pkg::DIV_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr_r};
    ge      = !trial[ldf_pkg::DIVISOR_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ldf_pkg::DIV_CNT_W'(ldf_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial[ldf_pkg::DIVISOR_W-1:0] : shifted[ldf_pkg::DIVISOR_W-1:0];
      quo_r <= {quo_r[ldf_pkg::DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> hdl/ldf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ldf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  ldf_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic                in_frame_end,
  input  ldf_pkg::dp_status_t status,
  output ldf_pkg::ctrl_cmd_t  cmd,
  output logic                in_stall
);

  ldf_pkg::ctrl_state_t          state_r, state_nxt;
  logic [ldf_pkg::LAG_W-1:0]     lag_r, lag_nxt;
  logic [ldf_pkg::WCNT_W-1:0]    idx_r, idx_nxt;
  logic                          accept;
  logic                          frame_go;
  logic                          idx_last;
  logic                          lag_shown;
  logic                          emit_ok;

  assign accept    = (state_r == ldf_pkg::ST_IDLE) && in_valid;
  assign frame_go  = accept && in_frame_end;
  assign idx_last  = (idx_r + 1'b1) == cfg.window;
  assign lag_shown = lag_r >= cfg.lag_start;
  assign emit_ok   = !lag_shown || status.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ldf_pkg::ST_IDLE: begin
        if (frame_go) begin
          state_nxt = (cfg.lag_start > cfg.lag_end) ? ldf_pkg::ST_FINISH : ldf_pkg::ST_LAG_INIT;
        end
      end
      ldf_pkg::ST_LAG_INIT: begin
        state_nxt = (cfg.window == '0) ? ldf_pkg::ST_DRAIN : ldf_pkg::ST_ISSUE;
      end
      ldf_pkg::ST_ISSUE: begin
        if (idx_last) begin
          state_nxt = ldf_pkg::ST_DRAIN;
        end
      end
      ldf_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ldf_pkg::ST_PREP;
        end
      end
      ldf_pkg::ST_PREP:      state_nxt = ldf_pkg::ST_DIV_START;
      ldf_pkg::ST_DIV_START: state_nxt = ldf_pkg::ST_DIV_WAIT;
      ldf_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_nxt = ldf_pkg::ST_EMIT;
        end
      end
      ldf_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_nxt = (lag_r == cfg.lag_end) ? ldf_pkg::ST_FINISH : ldf_pkg::ST_LAG_INIT;
        end
      end
      ldf_pkg::ST_FINISH: state_nxt = ldf_pkg::ST_IDLE;
      default:            state_nxt = ldf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lag_nxt = lag_r;
    idx_nxt = idx_r;
    if (frame_go) begin
      lag_nxt = (cfg.mode == ldf_pkg::MODE_YIN) ? '0 : cfg.lag_start;
    end
    if (state_r == ldf_pkg::ST_LAG_INIT) begin
      idx_nxt = '0;
    end
    if (state_r == ldf_pkg::ST_ISSUE) begin
      idx_nxt = idx_r + 1'b1;
    end
    if ((state_r == ldf_pkg::ST_EMIT) && emit_ok) begin
      lag_nxt = lag_r + 1'b1;
    end
  end

  always_comb begin
    in_stall       = (state_r != ldf_pkg::ST_IDLE);
    cmd.load       = accept;
    cmd.issue      = (state_r == ldf_pkg::ST_ISSUE);
    cmd.idx        = idx_r[ldf_pkg::IDX_W-1:0];
    cmd.lag        = lag_r;
    cmd.mac_clear  = (state_r == ldf_pkg::ST_LAG_INIT);
    cmd.sum_clear  = frame_go;
    cmd.prep       = (state_r == ldf_pkg::ST_PREP);
    cmd.div_start  = (state_r == ldf_pkg::ST_DIV_START);
    cmd.emit       = (state_r == ldf_pkg::ST_EMIT) && lag_shown && status.out_free;
    cmd.last       = (lag_r == cfg.lag_end);
    cmd.fill_clear = (state_r == ldf_pkg::ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldf_pkg::ST_IDLE;
      lag_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lag_r   <= lag_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ldf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ldf_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ldf_pkg::cfg_t                        cfg,
  input  ldf_pkg::ctrl_cmd_t                   cmd,
  input  logic signed [ldf_pkg::SAMPLE_BITS-1:0] in_sample,
  output ldf_pkg::dp_status_t                  status,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output ldf_pkg::out_item_t                   out_data
);

  logic signed [ldf_pkg::SAMPLE_BITS-1:0] store [ldf_pkg::STORE_DEPTH];

  logic [ldf_pkg::FILL_W-1:0]              fill_r;
  logic [ldf_pkg::ADDR_W-1:0]              addr_a, addr_b;
  logic signed [ldf_pkg::SAMPLE_BITS-1:0]  rd_a_r, rd_b_r;
  logic                                    ok_a_r, ok_b_r;
  logic                                    v1_r, v2_r;
  logic signed [ldf_pkg::SAMPLE_BITS-1:0]  a_s, b_s;
  logic signed [ldf_pkg::DIFF_W-1:0]       a_x, b_x, diff, op_x, op_y;
  logic [ldf_pkg::DIFF_W-1:0]              absd;
  logic signed [ldf_pkg::PROD_W-1:0]       prod, term, term_r;
  logic signed [ldf_pkg::ACC_W-1:0]        acc_r;
  logic [ldf_pkg::DIVISOR_W-1:0]           acc_u;
  logic [ldf_pkg::DIVISOR_W-1:0]           sum_r;
  logic [ldf_pkg::DIVISOR_W:0]             sum_ext;
  logic [ldf_pkg::DIVISOR_W+ldf_pkg::LAG_W-1:0] mul_full;
  logic [ldf_pkg::NUM_W-1:0]               num_r;
  logic [ldf_pkg::ACC_W-1:0]               acc_mag;
  logic                                    yin;
  logic [ldf_pkg::DIV_W-1:0]               dividend;
  logic [ldf_pkg::DIVISOR_W-1:0]           divisor;
  logic                                    zero_r, neg_r;
  logic                                    div_done;
  logic [ldf_pkg::DIV_W-1:0]               quotient;
  logic [ldf_pkg::VALUE_W-1:0]             q_lo;
  logic signed [ldf_pkg::VALUE_W-1:0]      value;
  logic                                    out_valid_r;
  ldf_pkg::out_item_t                      out_data_r;

  assign yin    = (cfg.mode == ldf_pkg::MODE_YIN);
  assign addr_a = ldf_pkg::ADDR_W'(cmd.idx);
  assign addr_b = ldf_pkg::ADDR_W'(cmd.idx) + ldf_pkg::ADDR_W'(cmd.lag);

  always_ff @(posedge clk) begin
    if (cmd.load && (fill_r < ldf_pkg::FILL_W'(ldf_pkg::STORE_DEPTH))) begin
      store[fill_r[ldf_pkg::ADDR_W-1:0]] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= store[addr_a];
    rd_b_r <= store[addr_b];
    ok_a_r <= ldf_pkg::FILL_W'(addr_a) < fill_r;
    ok_b_r <= ldf_pkg::FILL_W'(addr_b) < fill_r;
  end

  always_comb begin
    a_s  = ok_a_r ? rd_a_r : '0;
    b_s  = ok_b_r ? rd_b_r : '0;
    a_x  = ldf_pkg::DIFF_W'(a_s);
    b_x  = ldf_pkg::DIFF_W'(b_s);
    diff = a_x - b_x;
    absd = diff[ldf_pkg::DIFF_W-1] ? ldf_pkg::DIFF_W'(-diff) : ldf_pkg::DIFF_W'(diff);
    op_x = (cfg.mode == ldf_pkg::MODE_ACF) ? a_x : diff;
    op_y = (cfg.mode == ldf_pkg::MODE_ACF) ? b_x : diff;
    prod = op_x * op_y;
    term = (cfg.mode == ldf_pkg::MODE_AMDF) ? $signed(ldf_pkg::PROD_W'(absd)) : prod;
  end

  always_ff @(posedge clk) begin
    term_r <= term;
    if (cmd.mac_clear) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ldf_pkg::ACC_W'(term_r);
    end
  end

  always_comb begin
    acc_u    = acc_r;
    sum_ext  = {1'b0, sum_r} + {1'b0, acc_u};
    mul_full = acc_u * cmd.lag;
    acc_mag  = acc_r[ldf_pkg::ACC_W-1] ? ldf_pkg::ACC_W'(-acc_r) : ldf_pkg::ACC_W'(acc_r);
    dividend = yin ? {num_r, {ldf_pkg::FRAC_BITS{1'b0}}} : ldf_pkg::DIV_W'(acc_mag);
    divisor  = yin ? sum_r : ldf_pkg::DIVISOR_W'(cfg.window);
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      sum_r <= '0;
    end else if (cmd.prep && yin) begin
      sum_r <= sum_ext[ldf_pkg::DIVISOR_W] ? '1 : sum_ext[ldf_pkg::DIVISOR_W-1:0];
    end
    if (cmd.prep) begin
      num_r <= mul_full[ldf_pkg::NUM_W-1:0];
    end
    if (cmd.div_start) begin
      zero_r <= (divisor == '0);
      neg_r  <= !yin && acc_r[ldf_pkg::ACC_W-1];
    end
  end

  ldf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    q_lo = quotient[ldf_pkg::VALUE_W-1:0];
    if (zero_r) begin
      value = '0;
    end else if (yin) begin
      value = (|quotient[ldf_pkg::DIV_W-1:ldf_pkg::VALUE_W-1]) ? ldf_pkg::VALUE_MAX
                                                                : $signed(q_lo);
    end else begin
      value = neg_r ? -$signed(q_lo) : $signed(q_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.lag         <= cmd.lag;
      out_data_r.value       <= value;
      out_data_r.last_result <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fill_clear) begin
        fill_r <= '0;
      end else if (cmd.load && (fill_r < ldf_pkg::FILL_W'(ldf_pkg::STORE_DEPTH))) begin
        fill_r <= fill_r + 1'b1;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.pipe_busy = v1_r || v2_r;
  assign status.div_done  = div_done;
  assign status.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

`default_nettype wire

>>> hdl/lag_difference_function_core.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_data: sample, frame_end
// out_      output     out_valid / out_stall  out_data: lag, value, last_result
// config    input      psel/penable/pready    paddr, pwdata, prdata (32 bit)
//
// A request that is not the end of a frame is taken while the core is idle and does not stall the input.
// After the frame end, each lag runs setup, W terms on both read ports of the sample store,
// pipeline drain, the radix-2 divider and handoff, and waits while the output is not free;
// a window of zero skips the terms. A final state then closes the frame.
// In YIN mode lags below lag_start are computed, not emitted.
// Reset is synchronous and active low; the sample store needs no clearing.
// The input stalls while a frame is computed; a stalled output holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lag_difference_function_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ldf_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ldf_pkg::out_item_t                 out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ldf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ldf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ldf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  ldf_pkg::mode_t                 mode_r;
  logic [ldf_pkg::WLEN_W-1:0]     window_length_r;
  logic [ldf_pkg::LAG_W-1:0]      lag_start_r;
  logic [ldf_pkg::LAG_W-1:0]      lag_end_r;
  ldf_pkg::reg_idx_t              reg_idx;
  logic                           cfg_write;
  ldf_pkg::cfg_t                  cfg;
  ldf_pkg::ctrl_cmd_t             cmd;
  ldf_pkg::dp_status_t            status;

  assign pready    = 1'b1;
  assign reg_idx   = ldf_pkg::reg_idx_t'(paddr[ldf_pkg::CFG_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= ldf_pkg::MODE_RESET;
      window_length_r <= ldf_pkg::WLEN_RESET;
      lag_start_r     <= ldf_pkg::LAG_START_RESET;
      lag_end_r       <= ldf_pkg::LAG_END_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        ldf_pkg::REG_MODE:          mode_r <= ldf_pkg::mode_t'(pwdata[ldf_pkg::MODE_W-1:0]);
        ldf_pkg::REG_WINDOW_LENGTH: window_length_r <= pwdata[ldf_pkg::WLEN_W-1:0];
        ldf_pkg::REG_LAG_START:     lag_start_r <= pwdata[ldf_pkg::LAG_W-1:0];
        ldf_pkg::REG_LAG_END:       lag_end_r <= pwdata[ldf_pkg::LAG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ldf_pkg::REG_MODE:          prdata = ldf_pkg::CFG_DATA_W'(mode_r);
      ldf_pkg::REG_WINDOW_LENGTH: prdata = ldf_pkg::CFG_DATA_W'(window_length_r);
      ldf_pkg::REG_LAG_START:     prdata = ldf_pkg::CFG_DATA_W'(lag_start_r);
      ldf_pkg::REG_LAG_END:       prdata = ldf_pkg::CFG_DATA_W'(lag_end_r);
    endcase
  end

  always_comb begin
    cfg.mode      = mode_r;
    cfg.window    = (32'(window_length_r) > ldf_pkg::MAX_WINDOW)
                    ? ldf_pkg::WCNT_W'(ldf_pkg::MAX_WINDOW)
                    : ldf_pkg::WCNT_W'(window_length_r);
    cfg.lag_start = lag_start_r;
    cfg.lag_end   = lag_end_r;
  end

  ldf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_frame_end (in_data.frame_end),
    .status       (status),
    .cmd          (cmd),
    .in_stall     (in_stall)
  );

  ldf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_sample (in_data.sample),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_frame_end_stalls, in_valid && !in_stall && in_data.frame_end, in_stall, "input not stalled after frame end")
  `ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall), "result appeared while idle")

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ldf_pkg::*;

  localparam longint VALUE_POS = (64'sd1 <<< 47) - 1;
  localparam longint VALUE_NEG = -VALUE_POS - 1;
  localparam longint unsigned MASK48 = (64'd1 << 48) - 1;
  localparam int RANDOM_ITEMS = 430;
  localparam int LONG_HOLD = 6000;

  class lag_predictor;
    mode_t            mode;
    logic [WLEN_W-1:0] window;
    logic [LAG_W-1:0] lag_start;
    logic [LAG_W-1:0] lag_end;
    int               frame_samples[STORE_DEPTH];
    int               fill;
    longint unsigned  cumulative_sum;
    out_item_t        awaited_lags[$];
    int               errors;
    bit               last_frame_silent;

    function new();
      mode = MODE_RESET;
      window = WLEN_RESET;
      lag_start = LAG_START_RESET;
      lag_end = LAG_END_RESET;
      fill = 0;
      cumulative_sum = 0;
      errors = 0;
      last_frame_silent = 0;
    endfunction

    function void write_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MODE: mode = mode_t'(val[MODE_W-1:0]);
        REG_WINDOW_LENGTH: window = val[WLEN_W-1:0];
        REG_LAG_START: lag_start = val[LAG_W-1:0];
        REG_LAG_END: lag_end = val[LAG_W-1:0];
        default: ;
      endcase
    endfunction

    function int fetch(int idx);
      if (idx >= fill || idx >= STORE_DEPTH) return 0;
      return frame_samples[idx];
    endfunction

    function longint unsigned squared_diff_total(int w, int t);
      longint unsigned acc;
      longint d;
      acc = 0;
      for (int i = 0; i < w; i++) begin
        d = longint'(fetch(i)) - longint'(fetch(i + t));
        acc += longint'(d * d);
      end
      return acc;
    endfunction

    function longint clamp48(longint v);
      if (v > VALUE_POS) return VALUE_POS;
      if (v < VALUE_NEG) return VALUE_NEG;
      return v;
    endfunction

    function longint lag_mean(int w, int t);
      longint acc;
      longint a;
      longint b;
      longint unsigned sq;
      acc = 0;
      if (w == 0) return 0;
      if (mode == MODE_ASDF) begin
        sq = squared_diff_total(w, t) / longint'(w);
        return clamp48(longint'(sq));
      end
      for (int i = 0; i < w; i++) begin
        a = fetch(i);
        b = fetch(i + t);
        if (mode == MODE_ACF) acc += a * b;
        else acc += (a > b) ? (a - b) : (b - a);
      end
      return clamp48(acc / longint'(w));
    endfunction

    function longint yin_ratio(longint unsigned d, int t, longint unsigned s);
      longint unsigned num;
      longint unsigned ip;
      longint unsigned rem;
      longint unsigned fr;
      if (s == 0) return 0;
      num = d * longint'(t);
      ip = num / s;
      rem = num % s;
      if (ip >= (64'd1 << 31)) return VALUE_POS;
      fr = (rem << FRAC_BITS) / s;
      return longint'((ip << FRAC_BITS) | fr);
    endfunction

    function void note_request(in_item_t item);
      int w;
      int le;
      int produced;
      longint v;
      longint unsigned d;
      out_item_t want;
      if (fill < STORE_DEPTH) begin
        frame_samples[fill] = int'($signed(item.sample));
        fill++;
      end
      if (!item.frame_end) return;
      w = (window > MAX_WINDOW) ? MAX_WINDOW : int'(window);
      le = (lag_end > MAX_LAG - 1) ? MAX_LAG - 1 : int'(lag_end);
      cumulative_sum = 0;
      produced = 0;
      for (int t = 0; t <= le; t++) begin
        v = 0;
        if (mode == MODE_YIN) begin
          if (t > 0) begin
            d = squared_diff_total(w, t);
            if (d > MASK48) d = MASK48;
            cumulative_sum += d;
            if (cumulative_sum > MASK48) cumulative_sum = MASK48;
            v = yin_ratio(d, t, cumulative_sum);
          end
        end else if (t >= lag_start) begin
          v = lag_mean(w, t);
        end
        if (t >= lag_start) begin
          want.lag = t[LAG_W-1:0];
          want.value = v[VALUE_W-1:0];
          want.last_result = (t == le);
          awaited_lags.push_back(want);
          produced++;
        end
      end
      last_frame_silent = (produced == 0);
      fill = 0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_lags.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: lag %0d value %0d last %0b",
                   got.lag, got.value, got.last_result);
        errors++;
        return;
      end
      want = awaited_lags.pop_front();
      if (got.lag !== want.lag || got.value !== want.value ||
          got.last_result !== want.last_result) begin
        if (errors < 10)
          $display("mismatch: expected lag %0d value %0d last %0b, got lag %0d value %0d last %0b",
                   want.lag, want.value, want.last_result,
                   got.lag, got.value, got.last_result);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_lags.size();
    endfunction

    function int settle_cycles();
      int w;
      w = (window > MAX_WINDOW) ? MAX_WINDOW : int'(window);
      return last_frame_silent ? MAX_LAG * (w + 72) + 64 : 16;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lag_predictor lags = new();
  int burst_left = 0;
  bit long_hold_req = 0;

  lag_difference_function_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) lags.note_request(in_data);
    if (rst_n && out_valid && !out_stall) lags.check_result(out_data);
  end

  initial begin
    int hold_left;
    int run_left;
    int regime;
    hold_left = 0;
    run_left = 0;
    regime = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          regime = $urandom_range(0, 2);
          run_left = $urandom_range(10, 150);
        end
        run_left--;
        case (regime)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    lags.write_register(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input mode_t m, input int w, input int ls, input int le);
    apb_write(REG_MODE, CFG_DATA_W'(m));
    apb_write(REG_WINDOW_LENGTH, CFG_DATA_W'(w));
    apb_write(REG_LAG_START, CFG_DATA_W'(ls));
    apb_write(REG_LAG_END, CFG_DATA_W'(le));
  endtask

  task automatic send_request(input logic signed [SAMPLE_BITS-1:0] s, input logic fe);
    int gap;
    logic [SAMPLE_BITS:0] noise;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        noise = $urandom();
        in_valid <= 1'b0;
        in_data <= noise;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{sample: s, frame_end: fe};
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'($urandom_range(0, 63)) - 16'd32;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random_frame(input int len);
    for (int i = 0; i < len; i++) send_request(pick_sample(), i == len - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lags.pending() != 0) @(posedge clk);
    repeat (lags.settle_cycles()) @(posedge clk);
  endtask

  initial begin
    #20000000;
    $display("lag_difference_function_core verification failed");
    $finish;
  end

  initial begin
    int items_sent;
    int frame_len;
    int frame_count;
    int w_eff;
    int span;
    mode_t m;
    int w;
    int ls;
    int le;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_request(32767, 1'b0);
    send_request(-32768, 1'b0);
    send_request(0, 1'b0);
    send_request(-1, 1'b0);
    send_request(1, 1'b1);
    drain();
    configure(MODE_ACF, 4, 0, 5);
    send_request(-32768, 1'b0);
    send_request(-32768, 1'b0);
    send_request(32767, 1'b0);
    send_request(32767, 1'b0);
    send_request(-32768, 1'b0);
    send_request(1, 1'b1);
    drain();
    configure(MODE_AMDF, 0, 2, 4);
    send_request(32767, 1'b0);
    send_request(-32768, 1'b0);
    send_request(5, 1'b1);
    drain();
    configure(MODE_YIN, 1023, 0, 63);
    send_request(-32768, 1'b0);
    send_request(32767, 1'b0);
    send_request(-32768, 1'b0);
    send_request(32767, 1'b1);
    drain();
    configure(MODE_YIN, 8, 5, 10);
    send_request(100, 1'b0);
    send_request(-200, 1'b0);
    send_request(300, 1'b0);
    send_request(-400, 1'b1);
    send_request(0, 1'b0);
    send_request(0, 1'b1);
    drain();
    configure(MODE_YIN, 4, 10, 3);
    send_request(7, 1'b1);
    drain();

    configure(MODE_ACF, 4, 0, 63);
    send_random_frame(10);
    long_hold_req = 1;
    send_random_frame(10);
    send_random_frame(10);
    drain();

    configure(MODE_ACF, MAX_WINDOW, 60, 63);
    send_random_frame(STORE_DEPTH + 4);
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      m = mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = ($urandom_range(0, 1) == 0) ? MAX_WINDOW : $urandom_range(MAX_WINDOW + 1, 1023);
        default: w = $urandom_range(1, 24);
      endcase
      le = (w >= MAX_WINDOW) ? $urandom_range(0, 5) : $urandom_range(0, 63);
      ls = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, le);
      configure(m, w, ls, le);
      w_eff = (w > MAX_WINDOW) ? MAX_WINDOW : w;
      frame_count = $urandom_range(1, 4);
      repeat (frame_count) begin
        if ($urandom_range(0, 9) < 4) begin
          frame_len = $urandom_range(1, 8);
        end else begin
          span = (w_eff > 40) ? 40 : w_eff + le + 1;
          frame_len = $urandom_range(1, (span > 100) ? 100 : span);
        end
        send_random_frame(frame_len);
        items_sent += frame_len;
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (lags.errors == 0 && lags.pending() == 0) begin
      $display("lag_difference_function_core verification clean");
    end else begin
      $display("lag_difference_function_core verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/ldf_pkg.sv
hdl/ldf_divider.sv
hdl/ldf_ctrl.sv
hdl/ldf_datapath.sv
hdl/lag_difference_function_core.sv
bench/testbench.sv
